// File: sv/ssse_pkg.sv
// Shared types, constants and helpers of the scan slice selective encoder.
// Used by the channel interfaces and by every RTL module of the block.
package ssse_pkg;

  localparam int SCAN_CHAINS_DEF = 255;
  localparam int CODE_BITS_DEF   = 8;
  localparam int GROUP_COUNT_DEF = 32;

  localparam int BITS_W = 8;
  localparam int CTRL_W = 2;
  localparam int DATA_W = 8;

  localparam logic [CTRL_W-1:0] CTRL_TARGET_ONE  = 2'd0;
  localparam logic [CTRL_W-1:0] CTRL_TARGET_ZERO = 2'd1;
  localparam logic [CTRL_W-1:0] CTRL_COPY        = 2'd3;

  typedef struct packed {
    logic zero_hit;
    logic one_hit;
  } lane_hit_t;

  // Keeps the bits below code_bits and truncates to the data width.
  function automatic logic [DATA_W-1:0] fmt_data(logic [31:0] v, int code_bits);
    logic [DATA_W-1:0] r;
    r = '0;
    for (int b = 0; b < DATA_W; b++) begin
      if (b < code_bits) begin
        r[b] = v[b];
      end
    end
    return r;
  endfunction

endpackage

// File: sv/ssse_group_if.sv
// Input channel of the encoder: one group of scan bits and care mask per item.
// Depends on ssse_pkg for the field widths.
interface ssse_group_if;
  import ssse_pkg::*;

  logic              valid;
  logic              ready;
  logic [BITS_W-1:0] group_bits;
  logic [BITS_W-1:0] group_care;

  modport source (output valid, group_bits, group_care, input ready);
  modport sink (input valid, group_bits, group_care, output ready);
endinterface

// File: sv/ssse_word_if.sv
// Output channel of the encoder: one encoded word per item.
// Depends on ssse_pkg for the field widths.
interface ssse_word_if;
  import ssse_pkg::*;

  logic              valid;
  logic              ready;
  logic [CTRL_W-1:0] control_code;
  logic [DATA_W-1:0] data_code;
  logic              word_last;

  modport source (output valid, control_code, data_code, word_last, input ready);
  modport sink (input valid, control_code, data_code, word_last, output ready);
endinterface

// File: sv/ssse_lane.sv
// One bit lane: classifies a scan bit as specified zero, specified one or unspecified.
// Positions at or beyond the scan chain count are treated as unspecified. Uses ssse_pkg.
module ssse_lane #(
  parameter int SCAN_CHAINS = ssse_pkg::SCAN_CHAINS_DEF,
  parameter int PW          = 8
) (
  input  logic                  bit_val,
  input  logic                  care,
  input  logic [PW-1:0]         pos,
  output ssse_pkg::lane_hit_t   hit
);
  import ssse_pkg::*;

  logic spec;

  assign spec         = care && (32'(pos) < 32'(SCAN_CHAINS));
  assign hit.zero_hit = spec && !bit_val;
  assign hit.one_hit  = spec && bit_val;
endmodule

// File: sv/ssse_merge.sv
// Merging stage: combines the lane hits of each group into the slice statistics
// and derives the encoding decision. Uses ssse_pkg.
module ssse_merge #(
  parameter int SCAN_CHAINS = ssse_pkg::SCAN_CHAINS_DEF,
  parameter int CODE_BITS   = ssse_pkg::CODE_BITS_DEF,
  parameter int GW          = 5,
  parameter int PW          = 8
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  logic                                      clear,
  input  logic [GW-1:0]                             grp,
  input  logic [PW-1:0]                             pos_base,
  input  ssse_pkg::lane_hit_t [CODE_BITS-1:0]       hits,
  output logic                                      target_one,
  output logic                                      single,
  output logic [ssse_pkg::DATA_W-1:0]               pos_data,
  output logic [GW-1:0]                             start_grp,
  output logic [GW-1:0]                             end_grp
);
  import ssse_pkg::*;

  localparam int CNTW = $clog2(SCAN_CHAINS + 1);

  logic [CNTW-1:0] zero_count;
  logic [CNTW-1:0] one_count;
  logic [GW-1:0]   first0;
  logic [GW-1:0]   first1;
  logic [GW-1:0]   last0;
  logic [GW-1:0]   last1;
  logic [PW-1:0]   lastpos0;
  logic [PW-1:0]   lastpos1;

  logic [CODE_BITS-1:0] zvec;
  logic [CODE_BITS-1:0] ovec;
  logic [PW-1:0]        zoff;
  logic [PW-1:0]        ooff;
  logic [CNTW-1:0]      n;

  always_comb begin
    zoff = '0;
    ooff = '0;
    for (int sh = CODE_BITS - 1; sh >= 0; sh--) begin
      zvec[sh] = hits[sh].zero_hit;
      ovec[sh] = hits[sh].one_hit;
      if (hits[sh].zero_hit) begin
        zoff = PW'(CODE_BITS - 1 - sh);
      end
      if (hits[sh].one_hit) begin
        ooff = PW'(CODE_BITS - 1 - sh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      zero_count <= '0;
      one_count  <= '0;
    end else if (en) begin
      zero_count <= zero_count + CNTW'($countones(zvec));
      one_count  <= one_count + CNTW'($countones(ovec));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (|zvec) begin
        if (zero_count == '0) begin
          first0 <= grp;
        end
        last0    <= grp;
        lastpos0 <= pos_base + zoff;
      end
      if (|ovec) begin
        if (one_count == '0) begin
          first1 <= grp;
        end
        last1    <= grp;
        lastpos1 <= pos_base + ooff;
      end
    end
  end

  assign target_one = zero_count > one_count;
  assign n          = target_one ? one_count : zero_count;
  assign single     = n <= CNTW'(1);
  assign pos_data   = (n == '0) ? fmt_data(32'hFFFF_FFFF, CODE_BITS)
                    : fmt_data(32'(target_one ? lastpos1 : lastpos0), CODE_BITS);
  assign start_grp  = target_one ? first1 : first0;
  assign end_grp    = target_one ? last1 : last0;
endmodule

// File: sv/scan_slice_selective_encoder.sv
// Top level of the scan slice selective encoder: group store, bit lanes, merging
// stage, emission sequencer and output register. Uses ssse_pkg and both channel interfaces.
//
// The slice enters on group_in as GROUP_COUNT items, group 0 first, each with
// CODE_BITS scan bits and a care mask. Encoded words leave on word_out, word_last
// marking the final word of a slice. Groups are taken one per cycle.
// After the last group, the sequencer emits the words of the slice: a single-bit
// word from the header state, or a header word and a start word, followed by copy
// words, each of which waits for the registered read of the group store. No group
// is taken while words are emitted; groups of the next slice are taken as soon as
// the last word of the slice sits in the output register.
// A low word_out.ready holds the output word and stalls emission in place.
// Synchronous reset empties the output register and clears the group counter and
// the slice counts; the group store holds no reset value and needs none, since a
// slice writes every group before any is read back.
module scan_slice_selective_encoder #(
  parameter int SCAN_CHAINS = ssse_pkg::SCAN_CHAINS_DEF,
  parameter int CODE_BITS   = ssse_pkg::CODE_BITS_DEF,
  parameter int GROUP_COUNT = ssse_pkg::GROUP_COUNT_DEF
) (
  input logic          clk,
  input logic          rst,
  ssse_group_if.sink   group_in,
  ssse_word_if.source  word_out
);
  import ssse_pkg::*;

  localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int PW = $clog2(GROUP_COUNT * CODE_BITS);
  localparam int XW = (CODE_BITS > BITS_W) ? CODE_BITS : BITS_W;

  localparam logic [2:0] S_IN    = 3'd0;
  localparam logic [2:0] S_HEAD  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_COPY  = 3'd4;

  logic [2:0]           state;
  logic [GW-1:0]        grp;
  logic [PW-1:0]        pos_base;
  logic [GW-1:0]        rd_addr;
  logic [2*CODE_BITS-1:0] store [GROUP_COUNT];
  logic [2*CODE_BITS-1:0] rd_q;

  logic                 out_valid;
  logic [CTRL_W-1:0]    out_ctrl;
  logic [DATA_W-1:0]    out_data;
  logic                 out_last;

  logic                 accept;
  logic                 out_free;
  logic                 last_group;
  logic                 clear;
  logic [XW-1:0]        bits_x;
  logic [XW-1:0]        care_x;
  logic [CODE_BITS-1:0] bits_ext;
  logic [CODE_BITS-1:0] care_eff;
  lane_hit_t [CODE_BITS-1:0] hits;

  logic                 target_one;
  logic                 single;
  logic [DATA_W-1:0]    pos_data;
  logic [GW-1:0]        start_grp;
  logic [GW-1:0]        end_grp;

  logic [CODE_BITS-1:0] rd_bits;
  logic [CODE_BITS-1:0] rd_care;
  logic [CODE_BITS-1:0] fill;
  logic [CTRL_W-1:0]    head_ctrl;

  assign group_in.ready = (state == S_IN);
  assign accept         = group_in.valid && group_in.ready;
  assign out_free       = !out_valid || word_out.ready;
  assign last_group     = (grp == GW'(GROUP_COUNT - 1));

  assign bits_x   = XW'(group_in.group_bits);
  assign care_x   = XW'(group_in.group_care);
  assign bits_ext = bits_x[CODE_BITS-1:0];

  for (genvar sh = 0; sh < CODE_BITS; sh++) begin : g_lane
    ssse_lane #(
      .SCAN_CHAINS (SCAN_CHAINS),
      .PW          (PW)
    ) u_lane (
      .bit_val (bits_ext[sh]),
      .care    (care_x[sh]),
      .pos     (pos_base + PW'(CODE_BITS - 1 - sh)),
      .hit     (hits[sh])
    );
    assign care_eff[sh] = hits[sh].zero_hit || hits[sh].one_hit;
  end

  ssse_merge #(
    .SCAN_CHAINS (SCAN_CHAINS),
    .CODE_BITS   (CODE_BITS),
    .GW          (GW),
    .PW          (PW)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .en         (accept),
    .clear      (clear),
    .grp        (grp),
    .pos_base   (pos_base),
    .hits       (hits),
    .target_one (target_one),
    .single     (single),
    .pos_data   (pos_data),
    .start_grp  (start_grp),
    .end_grp    (end_grp)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      store[grp] <= {bits_ext, care_eff};
    end
    if (state == S_READ) begin
      rd_q <= store[rd_addr];
    end
  end

  assign rd_bits   = rd_q[2*CODE_BITS-1:CODE_BITS];
  assign rd_care   = rd_q[CODE_BITS-1:0];
  assign fill      = target_one ? (rd_bits & rd_care) : (rd_bits | ~rd_care);
  assign head_ctrl = target_one ? CTRL_TARGET_ONE : CTRL_TARGET_ZERO;

  assign clear = out_free && (((state == S_HEAD) && single)
                 || ((state == S_COPY) && (rd_addr == end_grp)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IN;
      grp       <= '0;
      pos_base  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= (state == S_HEAD) || (state == S_START) || (state == S_COPY);
      end
      case (state)
        S_IN: begin
          if (accept) begin
            if (last_group) begin
              grp      <= '0;
              pos_base <= '0;
              state    <= S_HEAD;
            end else begin
              grp      <= grp + GW'(1);
              pos_base <= pos_base + PW'(CODE_BITS);
            end
          end
        end
        S_HEAD: begin
          if (out_free) begin
            out_ctrl  <= head_ctrl;
            if (single) begin
              out_data <= pos_data;
              out_last <= 1'b1;
              state    <= S_IN;
            end else begin
              out_data <= fmt_data(32'hFFFF_FFFF, CODE_BITS);
              out_last <= 1'b0;
              state    <= S_START;
            end
          end
        end
        S_START: begin
          if (out_free) begin
            out_ctrl  <= CTRL_COPY;
            out_data  <= fmt_data(32'(start_grp), CODE_BITS);
            out_last  <= 1'b0;
            rd_addr   <= start_grp;
            state     <= S_READ;
          end
        end
        S_READ: begin
          state <= S_COPY;
        end
        S_COPY: begin
          if (out_free) begin
            out_ctrl  <= CTRL_COPY;
            out_data  <= fmt_data(32'(fill), CODE_BITS);
            if (rd_addr == end_grp) begin
              out_last <= 1'b1;
              state    <= S_IN;
            end else begin
              out_last <= 1'b0;
              rd_addr  <= rd_addr + GW'(1);
              state    <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IN;
        end
      endcase
    end
  end

  assign word_out.valid        = out_valid;
  assign word_out.control_code = out_ctrl;
  assign word_out.data_code    = out_data;
  assign word_out.word_last    = out_last;
endmodule
